/* rtl/idw_pkg.sv */
// Package: shared constants, types and the square root table for the IDW interpolator.
`timescale 1ns / 1ps

package idw_pkg;

    // Fixed point format of coordinates, values and weights
    localparam int FRAC_BITS = 16;
    localparam int CNT_W     = $clog2(FRAC_BITS);
    localparam int K_W       = 7;
    localparam int E_W       = 48;
    localparam int X_W       = FRAC_BITS + 7;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_POWER     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BANDWIDTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_RADIUS    = 2'd3;

    localparam logic [15:0] POWER_RESET  = 16'd512;
    localparam logic [31:0] BW_RESET     = 32'd65536;
    localparam logic [31:0] RADIUS_RESET = 32'd6553600;

    localparam logic [63:0] ONE         = 64'(1) << FRAC_BITS;
    localparam logic [63:0] CLAMP_EXP   = 64'(64) << FRAC_BITS;
    localparam logic [63:0] CLAMP_GAUSS = 64'(8) << FRAC_BITS;
    localparam logic [32:0] LOG2E_Q30   = 33'd1549082005;
    localparam logic [31:0] M_INIT      = 32'h4000_0000;

    // Range limits of the power-of-two stage
    localparam logic signed [E_W-1:0] EXP_HI   = E_W'(32 - FRAC_BITS) << FRAC_BITS;
    localparam logic signed [E_W-1:0] EXP_LO   = -(E_W'(64) << FRAC_BITS);
    localparam logic [E_W-1:0]        EXP_BIAS = E_W'(64) << FRAC_BITS;
    localparam logic signed [7:0]     SH_OFS   = 8'(FRAC_BITS - 94);

    typedef enum logic [1:0] {
        MODE_POWER,
        MODE_LINEAR,
        MODE_EXP,
        MODE_GAUSS
    } t_mode;

    typedef enum logic [4:0] {
        S_IDLE, S_SQ_X, S_SQ_Y, S_SQ_SUM, S_ROOT, S_ROOT_WAIT, S_MODE,
        S_NORM, S_LOG_MUL, S_LOG_UPD, S_LOG_POW, S_LOG_EXP,
        S_DIV_WAIT, S_GSQ, S_GSQ_SH, S_LGE, S_LGE_UPD,
        S_EXP_SET, S_EXP_MUL, S_EXP_UPD, S_EXP_SHIFT,
        S_ACC_MUL, S_ACC_ADD, S_FINISH, S_FDIV_WAIT, S_EMIT
    } t_state;

    typedef logic [31:0] t_root_tab [FRAC_BITS];

    // Successive square roots of 2.0 in Q2.30, entry j is 2^(1/2^(j+1))
    function automatic t_root_tab f_root_tab();
        t_root_tab   tab;
        logic [63:0] root;
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        root = 64'(1) << 31;
        for (int j = 0; j < FRAC_BITS; j++) begin
            v = root << 30;
            r = '0;
            b = 64'(1) << 62;
            for (int i = 0; i < 32; i++) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            root   = r;
            tab[j] = root[31:0];
        end
        return tab;
    endfunction

    localparam t_root_tab ROOT_TAB = f_root_tab();

endpackage

/* rtl/idw_in_if.sv */
// Interface: input channel carrying one neighbor point and the query position.
`timescale 1ns / 1ps

interface idw_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] query_x;
    logic [31:0] query_y;
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [31:0] point_value;
    logic        last_point;

    modport source (output valid, query_x, query_y, point_x, point_y, point_value,
                    last_point, input ready);
    modport sink (input valid, query_x, query_y, point_x, point_y, point_value,
                  last_point, output ready);
endinterface

/* rtl/idw_out_if.sv */
// Interface: output channel carrying one interpolation result.
`timescale 1ns / 1ps

interface idw_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] interpolated;
    logic        valid_res;

    modport source (output valid, interpolated, valid_res, input ready);
    modport sink (input valid, interpolated, valid_res, output ready);
endinterface

/* rtl/inverse_distance_weighted_interp.sv */
// Top level: inverse distance weighted interpolator with a shared multiplier sequencer.
`timescale 1ns / 1ps

// Each input item is one neighbor point with the query position; the item
// marked last_point ends the query and produces one result (weighted mean or
// the first exact hit in power mode). One item is in work at a time and the
// input is not ready meanwhile. An item takes the squares and the 32-step
// square root, plus the weight: power mode up to 32 normalize steps, 16 log
// squarings and 16 exp steps; linear mode one 64-step division; exponential
// and gaussian modes the division and the 16 exp steps. The last item adds
// the final 64-step division. A finished result sits in an output register
// while the next item is taken.

module inverse_distance_weighted_interp
    import idw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    idw_in_if.sink                i_in,
    idw_out_if.source             o_out
);

    t_state r_state;
    t_state n_state;

    t_mode       r_mode;
    logic [15:0] r_power;
    logic [31:0] r_bw;
    logic [31:0] r_radius;

    logic signed [63:0] r_wsum;
    logic [63:0]        r_sum_w;
    logic               r_hit_seen;
    logic [31:0]        r_hit_value;

    logic [31:0]          r_ax;
    logic [31:0]          r_ay;
    logic [31:0]          r_val;
    logic                 r_last;
    logic [64:0]          r_ss;
    logic [31:0]          r_d;
    logic [31:0]          r_m;
    logic [4:0]           r_msb;
    logic [CNT_W-1:0]     r_cnt;
    logic [FRAC_BITS-1:0] r_frac;
    logic signed [E_W-1:0] r_e;
    logic [K_W-1:0]       r_k;
    logic [X_W-1:0]       r_x;
    logic [31:0]          r_w;
    logic [31:0]          r_res;
    logic                 r_res_ok;
    logic                 r_o_valid;
    logic [31:0]          r_o_interp;
    logic                 r_o_valid_res;

    logic               in_acc;
    logic               in_ready;
    logic               emit_ok;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] prod;
    logic               div_start;
    logic [63:0]        div_dividend;
    logic [63:0]        div_divisor;
    logic               div_busy;
    logic               div_done;
    logic [63:0]        quot;
    logic               sqrt_start;
    logic               sqrt_busy;
    logic               sqrt_done;
    logic [31:0]        sqrt_root;

    logic signed [32:0]    dx;
    logic signed [32:0]    dy;
    logic signed [32:0]    adx;
    logic signed [32:0]    ady;
    logic                  lin_zero;
    logic [31:0]           sq;
    logic signed [7:0]     lexp;
    logic signed [E_W-1:0] l_full;
    logic signed [E_W-1:0] labs;
    logic [E_W-1:0]        t_pow;
    logic [E_W-1:0]        u;
    logic signed [7:0]     sh;
    logic [7:0]            sh_neg;
    logic [31:0]           w_shift;
    logic [CNT_W-1:0]      f_idx;
    logic signed [63:0]    p;
    logic signed [64:0]    acc_sum;
    logic [64:0]           wt_sum;
    logic [63:0]           mag;

    idw_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    idw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    idw_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (r_ss[63:0]),
        .o_busy     (sqrt_busy),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    assign in_acc  = i_in.valid && in_ready;
    assign emit_ok = !r_o_valid || o_out.ready;

    // Coordinate differences and their magnitudes
    assign dx  = signed'({i_in.point_x[31], i_in.point_x})
               - signed'({i_in.query_x[31], i_in.query_x});
    assign dy  = signed'({i_in.point_y[31], i_in.point_y})
               - signed'({i_in.query_y[31], i_in.query_y});
    assign adx = dx[32] ? -dx : dx;
    assign ady = dy[32] ? -dy : dy;

    assign lin_zero = (r_radius == '0) || (r_d >= r_radius);
    assign sq       = prod[61:30];

    // Log2 from exponent and fraction bits
    assign lexp   = signed'({3'b000, r_msb}) - signed'(8'(FRAC_BITS));
    assign l_full = {{(E_W - 8 - FRAC_BITS){lexp[7]}}, lexp, r_frac};
    assign labs   = lexp[7] ? -l_full : l_full;
    assign t_pow  = prod[E_W+7:8];

    // Power-of-two stage: split exponent, final shift
    assign u       = r_e + EXP_BIAS;
    assign sh      = signed'({1'b0, r_k}) + SH_OFS;
    assign sh_neg  = -sh;
    assign w_shift = sh[7] ? (r_m >> sh_neg) : (r_m << sh[0]);
    assign f_idx   = CNT_W'(FRAC_BITS - 1) - r_cnt;

    // Saturating accumulation
    assign p       = prod[63:0];
    assign acc_sum = {r_wsum[63], r_wsum} + {p[63], p};
    assign wt_sum  = {1'b0, r_sum_w} + 65'(r_w);
    assign mag     = r_wsum[63] ? 64'(-r_wsum) : 64'(r_wsum);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (in_acc) n_state = r_hit_seen ? S_FINISH : S_SQ_X;
            S_SQ_X:      n_state = S_SQ_Y;
            S_SQ_Y:      n_state = S_SQ_SUM;
            S_SQ_SUM:    n_state = S_ROOT;
            S_ROOT:      n_state = r_ss[64] ? S_MODE : S_ROOT_WAIT;
            S_ROOT_WAIT: if (sqrt_done) n_state = S_MODE;
            S_MODE: begin
                case (r_mode)
                    MODE_POWER:  n_state = (r_d == '0) ? S_FINISH : S_NORM;
                    MODE_LINEAR: n_state = lin_zero ? S_ACC_MUL : S_DIV_WAIT;
                    default:     n_state = (r_bw == '0) ? S_ACC_MUL : S_DIV_WAIT;
                endcase
            end
            S_NORM:      if (r_m[31]) n_state = S_LOG_MUL;
            S_LOG_MUL:   n_state = S_LOG_UPD;
            S_LOG_UPD:   n_state = (r_cnt == '0) ? S_LOG_POW : S_LOG_MUL;
            S_LOG_POW:   n_state = S_LOG_EXP;
            S_LOG_EXP:   n_state = S_EXP_SET;
            S_DIV_WAIT: begin
                if (div_done) begin
                    case (r_mode)
                        MODE_EXP:   n_state = S_LGE;
                        MODE_GAUSS: n_state = S_GSQ;
                        default:    n_state = S_ACC_MUL;
                    endcase
                end
            end
            S_GSQ:       n_state = S_GSQ_SH;
            S_GSQ_SH:    n_state = S_LGE;
            S_LGE:       n_state = S_LGE_UPD;
            S_LGE_UPD:   n_state = S_EXP_SET;
            S_EXP_SET:   n_state = (r_e >= EXP_HI || r_e < EXP_LO) ? S_ACC_MUL : S_EXP_MUL;
            S_EXP_MUL:   n_state = S_EXP_UPD;
            S_EXP_UPD:   n_state = (r_cnt == CNT_W'(FRAC_BITS - 1)) ? S_EXP_SHIFT : S_EXP_MUL;
            S_EXP_SHIFT: n_state = S_ACC_MUL;
            S_ACC_MUL:   n_state = S_ACC_ADD;
            S_ACC_ADD:   n_state = S_FINISH;
            S_FINISH: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (r_hit_seen || r_sum_w == '0) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_FDIV_WAIT;
                end
            end
            S_FDIV_WAIT: if (div_done) n_state = S_EMIT;
            S_EMIT:      if (emit_ok) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Unit controls and operand selection
    always_comb begin
        in_ready     = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = 64'(r_d) << FRAC_BITS;
        div_divisor  = (r_mode == MODE_LINEAR) ? 64'(r_radius) : 64'(r_bw);
        sqrt_start   = 1'b0;
        case (r_state)
            S_IDLE: in_ready = 1'b1;
            S_SQ_X: begin
                mul_a = {1'b0, r_ax};
                mul_b = {1'b0, r_ax};
            end
            S_SQ_Y: begin
                mul_a = {1'b0, r_ay};
                mul_b = {1'b0, r_ay};
            end
            S_ROOT: sqrt_start = !r_ss[64];
            S_MODE: begin
                case (r_mode)
                    MODE_POWER:  div_start = 1'b0;
                    MODE_LINEAR: div_start = !lin_zero;
                    default:     div_start = (r_bw != '0);
                endcase
            end
            S_LOG_MUL: begin
                mul_a = {1'b0, r_m};
                mul_b = {1'b0, r_m};
            end
            S_LOG_POW: begin
                mul_a = {17'd0, r_power};
                mul_b = labs[32:0];
            end
            S_GSQ: begin
                mul_a = 33'(r_x);
                mul_b = 33'(r_x);
            end
            S_LGE: begin
                mul_a = 33'(r_x);
                mul_b = LOG2E_Q30;
            end
            S_EXP_MUL: begin
                mul_a = {1'b0, r_m};
                mul_b = {1'b0, ROOT_TAB[r_cnt]};
            end
            S_ACC_MUL: begin
                mul_a = {1'b0, r_w};
                mul_b = {r_val[31], r_val};
            end
            S_FINISH: begin
                div_start    = r_last && !r_hit_seen && (r_sum_w != '0);
                div_dividend = mag;
                div_divisor  = r_sum_w;
            end
            default: in_ready = 1'b0;
        endcase
    end

    // Control state, configuration and query accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mode     <= MODE_POWER;
            r_power    <= POWER_RESET;
            r_bw       <= BW_RESET;
            r_radius   <= RADIUS_RESET;
            r_wsum     <= '0;
            r_sum_w    <= '0;
            r_hit_seen <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IDX_MODE:      r_mode   <= t_mode'(i_cfg_data[1:0]);
                    CFG_IDX_POWER:     r_power  <= i_cfg_data[15:0];
                    CFG_IDX_BANDWIDTH: r_bw     <= i_cfg_data;
                    CFG_IDX_RADIUS:    r_radius <= i_cfg_data;
                    default:           r_mode   <= r_mode;
                endcase
            end
            if (r_state == S_MODE && r_mode == MODE_POWER && r_d == '0) begin
                r_hit_seen <= 1'b1;
            end
            // Add the weighted value and the weight, saturating
            if (r_state == S_ACC_ADD) begin
                if (acc_sum[64] != acc_sum[63]) begin
                    r_wsum <= acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                end else begin
                    r_wsum <= acc_sum[63:0];
                end
                r_sum_w <= wt_sum[64] ? '1 : wt_sum[63:0];
            end
            // Drop the output item when taken, load a new result, clear the query
            if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
            if (r_state == S_EMIT && emit_ok) begin
                r_o_valid  <= 1'b1;
                r_wsum     <= '0;
                r_sum_w    <= '0;
                r_hit_seen <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_ax   <= adx[31:0];
                    r_ay   <= ady[31:0];
                    r_val  <= i_in.point_value;
                    r_last <= i_in.last_point;
                end
            end
            S_SQ_Y:   r_ss <= {1'b0, prod[63:0]};
            S_SQ_SUM: r_ss <= r_ss + {1'b0, prod[63:0]};
            S_ROOT:   if (r_ss[64]) r_d <= '1;
            S_ROOT_WAIT: if (sqrt_done) r_d <= sqrt_root;
            S_MODE: begin
                r_m         <= r_d;
                r_msb       <= '1;
                r_w         <= '0;
                r_hit_value <= r_val;
            end
            // Normalize so the top bit is set
            S_NORM: begin
                if (r_m[31]) begin
                    r_m    <= r_m >> 1;
                    r_cnt  <= CNT_W'(FRAC_BITS - 1);
                    r_frac <= '0;
                end else begin
                    r_m   <= r_m << 1;
                    r_msb <= r_msb - 5'd1;
                end
            end
            // One log2 fraction bit per squaring
            S_LOG_UPD: begin
                if (sq[31]) begin
                    r_frac[r_cnt] <= 1'b1;
                    r_m           <= sq >> 1;
                end else begin
                    r_m <= sq;
                end
                r_cnt <= r_cnt - CNT_W'(1);
            end
            S_LOG_EXP: r_e <= lexp[7] ? signed'(t_pow) : -signed'(t_pow);
            S_DIV_WAIT: begin
                if (div_done) begin
                    case (r_mode)
                        MODE_LINEAR: r_w <= 32'(ONE - quot);
                        MODE_EXP:    r_x <= X_W'((quot > CLAMP_EXP) ? CLAMP_EXP : quot);
                        MODE_GAUSS:  r_x <= X_W'((quot > CLAMP_GAUSS) ? CLAMP_GAUSS : quot);
                        default:     r_w <= '0;
                    endcase
                end
            end
            S_GSQ_SH:  r_x <= prod[FRAC_BITS+1 +: X_W];
            S_LGE_UPD: r_e <= -signed'(E_W'(prod[65:30]));
            S_EXP_SET: begin
                r_w    <= (r_e >= EXP_HI) ? '1 : '0;
                r_k    <= u[FRAC_BITS +: K_W];
                r_frac <= u[FRAC_BITS-1:0];
                r_m    <= M_INIT;
                r_cnt  <= '0;
            end
            // Multiply in root j where fraction bit FRAC_BITS-1-j is set
            S_EXP_UPD: begin
                if (r_frac[f_idx]) begin
                    r_m <= sq;
                end
                r_cnt <= r_cnt + CNT_W'(1);
            end
            S_EXP_SHIFT: r_w <= w_shift;
            S_FINISH: begin
                r_res    <= r_hit_seen ? r_hit_value : '0;
                r_res_ok <= r_hit_seen;
            end
            // Clamp the quotient to the signed 32-bit range
            S_FDIV_WAIT: begin
                if (div_done) begin
                    if (r_wsum[63]) begin
                        r_res <= (quot > 64'h8000_0000) ? 32'h8000_0000 : 32'(-quot);
                    end else begin
                        r_res <= (quot > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quot[31:0];
                    end
                    r_res_ok <= 1'b1;
                end
            end
            S_EMIT: begin
                if (emit_ok) begin
                    r_o_interp    <= r_res;
                    r_o_valid_res <= r_res_ok;
                end
            end
            default: r_res_ok <= r_res_ok;
        endcase
    end

    assign i_in.ready         = in_ready;
    assign o_out.valid        = r_o_valid;
    assign o_out.interpolated = r_o_interp;
    assign o_out.valid_res    = r_o_valid_res;

    // The divider is started only when it is free
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // No unit is left running when the block takes a new item
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!div_busy && !sqrt_busy))
        else $error("arithmetic unit busy in idle");

    // After an exact hit further points skip the arithmetic
    a_hit_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_hit_seen) |=> (r_state == S_FINISH))
        else $error("point processed after exact hit");

    // An empty result reads as zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.valid_res) |-> (o_out.interpolated == '0))
        else $error("invalid result carries a value");

endmodule

/* rtl/idw_mul.sv */
// Shared 33x33 signed multiplier with a registered product.
`timescale 1ns / 1ps

module idw_mul
    import idw_pkg::*;
(
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [65:0] o_prod
);

    logic signed [65:0] r_prod;

    // Register every product
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

/* rtl/idw_div.sv */
// Restoring divider, 64-bit unsigned, one quotient bit per cycle.
`timescale 1ns / 1ps

module idw_div
    import idw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [63:0] i_divisor,
    output logic        o_busy,
    output logic        o_done,
    output logic [63:0] o_quot
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_rem;
    logic [63:0] r_quo;
    logic [63:0] r_den;
    logic [64:0] trial;
    logic        ge;

    assign trial = {r_rem, r_quo[63]};
    assign ge    = trial >= {1'b0, r_den};

    // Sequence the 64 steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift in one quotient bit a step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? 64'(trial - {1'b0, r_den}) : trial[63:0];
            r_quo <= {r_quo[62:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

/* rtl/idw_sqrt.sv */
// Integer square root of a 64-bit value, one result bit per cycle.
`timescale 1ns / 1ps

module idw_sqrt
    import idw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_radicand,
    output logic        o_busy,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic        r_busy;
    logic        r_done;
    logic [63:0] r_v;
    logic [63:0] r_r;
    logic [63:0] r_bit;
    logic [63:0] trial;
    logic        ge;

    assign trial = r_r + r_bit;
    assign ge    = r_v >= trial;

    // Sequence the 32 steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit == 64'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Try one root bit a step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_radicand;
            r_r   <= '0;
            r_bit <= 64'(1) << 62;
        end else if (r_busy) begin
            if (ge) begin
                r_v <= r_v - trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_root = r_r[31:0];

endmodule

/* bench/inverse_distance_weighted_interp_tb.sv */
// Testbench for the IDW interpolator: checks every result against an in-bench predictor.
`timescale 1ns / 1ps

module inverse_distance_weighted_interp_tb;
    import idw_pkg::*;

    // Input item as seen by the bench
    typedef struct packed {
        logic [31:0] qx;
        logic [31:0] qy;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pv;
        logic        last;
    } t_point;

    typedef struct packed {
        logic [31:0] interp;
        logic        vres;
    } t_interp;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    idw_in_if  in_ch ();
    idw_out_if out_ch ();

    inverse_distance_weighted_interp u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    // Predictor state and configuration
    t_mode       mdl_mode;
    logic [15:0] mdl_power;
    logic [31:0] mdl_bw;
    logic [31:0] mdl_radius;
    logic signed [63:0] acc_wz = '0;
    logic [63:0] acc_w = '0;
    logic        hit_seen = 1'b0;
    logic [31:0] hit_val = '0;

    t_point  pending_points [$];
    t_interp expected_interp [$];
    int      err_count = 0;
    int      items_sent = 0;
    int      results_seen = 0;
    int      hits_seen = 0;
    logic    driver_hold;

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'(1) << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] pow2_q(logic signed [63:0] e);
        logic [63:0] u;
        logic [63:0] k;
        logic [63:0] f;
        logic [63:0] m;
        logic [63:0] root;
        int s;
        if (e >= 64'sd16 * 64'sd65536) return 32'hFFFF_FFFF;
        if (e < -(64'sd64 * 64'sd65536)) return 0;
        u = e + 64'sd64 * 64'sd65536;
        k = u >> FRAC_BITS;
        f = u & (ONE - 1);
        m = 64'(1) << 30;
        root = 64'(1) << 31;
        for (int j = 1; j <= FRAC_BITS; j++) begin
            root = isqrt(root << 30);
            if (f[FRAC_BITS - j]) m = (m * root) >> 30;
        end
        s = int'(k) + FRAC_BITS - 94;
        if (s >= 0) return 32'((m << s));
        if (-s >= 64) return 0;
        return 32'(m >> (-s));
    endfunction

    function automatic logic signed [63:0] log2_q(logic [31:0] d);
        int msb;
        logic [63:0] m;
        logic [63:0] frac;
        msb = 31;
        frac = 0;
        while (msb > 0 && !d[msb]) msb--;
        m = (64'(d) << 30) >> msb;
        for (int i = FRAC_BITS - 1; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (64'(1) << 31)) begin
                frac[i] = 1'b1;
                m = m >> 1;
            end
        end
        return 64'(msb - FRAC_BITS) * 64'sd65536 + $signed(frac);
    endfunction

    function automatic logic [31:0] weight_for(logic [31:0] d);
        logic [63:0] q;
        logic [63:0] x;
        logic [63:0] t;
        logic [127:0] xl;
        logic signed [63:0] l;
        case (mdl_mode)
            MODE_LINEAR: begin
                if (mdl_radius == 0 || d >= mdl_radius) return 0;
                return 32'(ONE - ((64'(d) << FRAC_BITS) / mdl_radius));
            end
            MODE_EXP, MODE_GAUSS: begin
                if (mdl_bw == 0) return 0;
                q = (64'(d) << FRAC_BITS) / mdl_bw;
                if (mdl_mode == MODE_EXP) begin
                    x = (q > CLAMP_EXP) ? CLAMP_EXP : q;
                end else begin
                    if (q > CLAMP_GAUSS) q = CLAMP_GAUSS;
                    x = (q * q) >> (FRAC_BITS + 1);
                end
                xl = 128'(x) * 128'(LOG2E_Q30);
                return pow2_q(-$signed(64'(xl >> 30)));
            end
            default: begin
                l = log2_q(d);
                t = (64'(mdl_power) * 64'(l < 0 ? -l : l)) >> 8;
                return pow2_q(l < 0 ? $signed(t) : -$signed(t));
            end
        endcase
    endfunction

    // Advance the predictor by one point; push a result on the last one
    task automatic predict_point(t_point p);
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic [63:0] ax;
        logic [63:0] ay;
        logic [63:0] sx;
        logic [63:0] ss;
        logic [31:0] d;
        logic [31:0] w;
        logic signed [63:0] prod;
        logic signed [64:0] sum;
        logic [64:0] wsum;
        logic [63:0] mag;
        logic [63:0] q;
        t_interp r;
        dx = $signed(p.px) - $signed(p.qx);
        dy = $signed(p.py) - $signed(p.qy);
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        sx = ax * ax;
        ss = sx + ay * ay;
        if (!hit_seen) begin
            d = (ss < sx) ? 32'hFFFF_FFFF : 32'(isqrt(ss));
            if (mdl_mode == MODE_POWER && d == 0) begin
                hit_seen = 1'b1;
                hit_val = p.pv;
            end else begin
                w = weight_for(d);
                prod = $signed({32'd0, w}) * $signed(p.pv);
                sum = 65'(acc_wz) + 65'(prod);
                if (sum > 65'sh0_7FFF_FFFF_FFFF_FFFF) acc_wz = 64'sh7FFF_FFFF_FFFF_FFFF;
                else if (sum < -65'sh0_8000_0000_0000_0000) acc_wz = 64'sh8000_0000_0000_0000;
                else acc_wz = sum[63:0];
                wsum = 65'(acc_w) + 65'(w);
                acc_w = wsum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : wsum[63:0];
            end
        end
        if (p.last) begin
            if (hit_seen) begin
                r = '{hit_val, 1'b1};
            end else if (acc_w == 0) begin
                r = '{32'd0, 1'b0};
            end else begin
                mag = acc_wz < 0 ? 64'(-acc_wz) : 64'(acc_wz);
                q = mag / acc_w;
                if (acc_wz < 0) begin
                    if (q > 64'h8000_0000) q = 64'h8000_0000;
                    r = '{32'(-q), 1'b1};
                end else begin
                    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
                    r = '{q[31:0], 1'b1};
                end
            end
            expected_interp.push_back(r);
            acc_wz = 0;
            acc_w = 0;
            hit_seen = 0;
            hit_val = 0;
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // Clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Driver: wait out a random gap, then present the next pending point
    int in_gap;
    int in_draw;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            {in_ch.query_x, in_ch.query_y, in_ch.point_x, in_ch.point_y,
             in_ch.point_value, in_ch.last_point} <= t_point'(0);
            in_gap <= $urandom_range(0, 9);
        end else if (in_ch.valid && in_ch.ready) begin
            predict_point(pending_points.pop_front());
            items_sent++;
            in_draw = $urandom_range(0, 9);
            in_gap <= in_draw;
            if (in_draw == 0 && !driver_hold && pending_points.size() > 0) begin
                {in_ch.query_x, in_ch.query_y, in_ch.point_x, in_ch.point_y,
                 in_ch.point_value, in_ch.last_point} <= pending_points[0];
            end else begin
                in_ch.valid <= 1'b0;
            end
        end else if (!in_ch.valid) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
            end else if (!driver_hold && pending_points.size() > 0) begin
                in_ch.valid <= 1'b1;
                {in_ch.query_x, in_ch.query_y, in_ch.point_x, in_ch.point_y,
                 in_ch.point_value, in_ch.last_point} <= pending_points[0];
            end
        end
    end

    // Monitor: random back-pressure, compare each accepted result
    int out_gap;
    t_interp want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            out_gap <= $urandom_range(0, 9);
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (expected_interp.size() == 0) begin
                    report_mismatch("unexpected result", out_ch.interpolated, 32'd0);
                end else begin
                    want = expected_interp.pop_front();
                    if (out_ch.interpolated !== want.interp)
                        report_mismatch("interpolated", out_ch.interpolated, want.interp);
                    if (out_ch.valid_res !== want.vres)
                        report_mismatch("valid_res", 32'(out_ch.valid_res), 32'(want.vres));
                    if (want.vres && want.interp != 0) hits_seen++;
                end
                out_gap <= $urandom_range(0, 9);
                out_ch.ready <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_IDX_MODE:      mdl_mode = t_mode'(data[1:0]);
            CFG_IDX_POWER:     mdl_power = data[15:0];
            CFG_IDX_BANDWIDTH: mdl_bw = data;
            default:           mdl_radius = data;
        endcase
    endtask

    // Wait for the block to drain: queue empty, no result due, then slack
    task automatic drain();
        wait (pending_points.size() == 0 && !in_ch.valid && expected_interp.size() == 0);
        repeat (400) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord(int spread);
        if (spread == 0) return $urandom;
        return 32'($signed($urandom_range(0, 2 * spread)) - spread);
    endfunction

    task automatic add_point(logic [31:0] qx, logic [31:0] qy, logic [31:0] px,
                             logic [31:0] py, logic [31:0] pv, logic last);
        pending_points.push_back('{qx, qy, px, py, pv, last});
    endtask

    // Random queries: mostly nearby points, some full range, some exact hits
    task automatic random_queries(int n_items);
        logic [31:0] qx;
        logic [31:0] qy;
        int spread;
        int left;
        int len;
        left = n_items;
        while (left > 0) begin
            len = $urandom_range(1, 6);
            spread = ($urandom_range(0, 9) == 0) ? 0 : (1 << $urandom_range(4, 22));
            qx = rand_coord(spread);
            qy = rand_coord(spread);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 15) == 0)
                    add_point(qx, qy, qx, qy, $urandom, k == len - 1);
                else
                    add_point(qx, qy, qx + rand_coord(spread), qy + rand_coord(spread),
                              $urandom, k == len - 1);
            end
            left -= len;
        end
    endtask

    initial begin
        driver_hold = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_IDX_MODE;
        i_cfg_data = '0;
        mdl_mode = MODE_POWER;
        mdl_power = POWER_RESET;
        mdl_bw = BW_RESET;
        mdl_radius = RADIUS_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset settings, extremes, exact hit, empty weight, no last mark
        add_point(32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'h7FFF_FFFF, 1'b0);
        add_point(32'd0, 32'd0, 32'd0, 32'h0002_0000, 32'h8000_0000, 1'b1);
        add_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h0001_0000, 1'b1);
        add_point(32'h1234_0000, 32'd5, 32'h1234_0000, 32'd5, 32'hDEAD_BEEF, 1'b0);
        add_point(32'd0, 32'd0, 32'd7, 32'd7, 32'd99, 1'b1);
        add_point(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 1'b1);
        drain();

        cfg_write(CFG_IDX_MODE, 32'(MODE_LINEAR));
        cfg_write(CFG_IDX_RADIUS, 32'd0);
        add_point(32'd0, 32'd0, 32'd1, 32'd1, 32'd1000, 1'b1);
        drain();
        cfg_write(CFG_IDX_RADIUS, 32'hFFFF_FFFF);
        add_point(32'd0, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 1'b0);
        add_point(32'd0, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 1'b1);
        add_point(32'h8000_0000, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'd5, 1'b1);
        drain();

        cfg_write(CFG_IDX_MODE, 32'(MODE_EXP));
        cfg_write(CFG_IDX_BANDWIDTH, 32'd0);
        add_point(32'd0, 32'd0, 32'd3, 32'd0, 32'd42, 1'b1);
        drain();
        cfg_write(CFG_IDX_BANDWIDTH, 32'hFFFF_FFFF);
        add_point(32'd0, 32'd0, 32'h0100_0000, 32'd0, 32'h8000_0000, 1'b1);
        drain();
        cfg_write(CFG_IDX_MODE, 32'(MODE_GAUSS));
        cfg_write(CFG_IDX_BANDWIDTH, 32'd1);
        add_point(32'd0, 32'd0, 32'd0, 32'd0, 32'd77, 1'b0);
        add_point(32'd0, 32'd0, 32'd100, 32'd0, 32'd77, 1'b1);
        drain();
        cfg_write(CFG_IDX_MODE, 32'(MODE_POWER));
        cfg_write(CFG_IDX_POWER, 32'd0);
        add_point(32'd0, 32'd0, 32'h0003_0000, 32'd0, 32'd12345, 1'b1);
        drain();
        cfg_write(CFG_IDX_POWER, 32'hFFFF);
        add_point(32'd0, 32'd0, 32'd1, 32'd0, 32'h0001_0000, 1'b0);
        add_point(32'd0, 32'd0, 32'h0010_0000, 32'd0, 32'hFFFF_0000, 1'b1);
        drain();

        // Random phases over a spread of settings, extremes included
        for (int ph = 0; ph < 10; ph++) begin
            cfg_write(CFG_IDX_MODE, ph % 4);
            cfg_write(CFG_IDX_POWER, (ph == 9) ? 32'hFFFF : $urandom_range(0, 1024));
            cfg_write(CFG_IDX_BANDWIDTH, (ph == 8) ? 32'hFFFF_FFFF : $urandom_range(1, 1 << 24));
            cfg_write(CFG_IDX_RADIUS, (ph == 7) ? 32'hFFFF_FFFF : $urandom_range(0, 1 << 26));
            random_queries(52);
            // Hold the sender once until the block has caught up
            if (ph == 4) begin
                wait (pending_points.size() < 14);
                driver_hold = 1'b1;
                wait (expected_interp.size() == 0 && !in_ch.valid);
                repeat (300) @(posedge i_clk);
                driver_hold = 1'b0;
            end
            drain();
        end

        $display("run covered %0d points and %0d results over all four weighting modes",
                 items_sent, results_seen);
        $display("%0d results carried a nonzero value", hits_seen);
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule

/* files.f */
rtl/idw_pkg.sv
rtl/idw_in_if.sv
rtl/idw_out_if.sv
rtl/idw_mul.sv
rtl/idw_div.sv
rtl/idw_sqrt.sv
rtl/inverse_distance_weighted_interp.sv
bench/inverse_distance_weighted_interp_tb.sv
